// ----- sv/complex_arith_unit_defines.svh -----
// Assertion macros used by the complex arithmetic unit source.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// A condition that holds at every clock edge outside reset.
`define CAU_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("complex_arith_unit assertion failed");
// A consequence that holds in the same cycle as its cause.
`define CAU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("complex_arith_unit assertion failed");
// A consequence that holds in the cycle after its cause.
`define CAU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("complex_arith_unit assertion failed");
`else
`define CAU_ASSERT(lbl, expr)
`define CAU_ASSERT_IMP(lbl, ante, cons)
`define CAU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/cau_pkg.sv -----
`timescale 1ns / 1ps
// Package with operation codes, status codes and default widths of the complex ALU.
package cau_pkg;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int DEF_FRAC_BITS = 24;
	localparam int OP_W = 3;
	localparam int ST_W = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV = 3'd3;
	localparam logic [OP_W-1:0] OP_CONJ = 3'd4;
	localparam logic [OP_W-1:0] OP_MOD = 3'd5;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_DIV_ZERO = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;
endpackage

// ----- sv/cau_req_if.sv -----
`timescale 1ns / 1ps
// Request channel interface: operation code and two complex operands.
interface cau_req_if #(
	parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH
) ();
	import cau_pkg::*;

	logic valid;
	logic ready;
	logic [OP_W-1:0] req_type;
	logic signed [DATA_WIDTH-1:0] first_real;
	logic signed [DATA_WIDTH-1:0] first_imag;
	logic signed [DATA_WIDTH-1:0] second_real;
	logic signed [DATA_WIDTH-1:0] second_imag;

	modport source (
		output valid, req_type, first_real, first_imag, second_real, second_imag,
		input ready
	);
	modport sink (
		input valid, req_type, first_real, first_imag, second_real, second_imag,
		output ready
	);
endinterface

// ----- sv/cau_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel interface: complex result and status.
interface cau_rsp_if #(
	parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH
) ();
	import cau_pkg::*;

	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] result_real;
	logic signed [DATA_WIDTH-1:0] result_imag;
	logic [ST_W-1:0] status;

	modport source (output valid, result_real, result_imag, status, input ready);
	modport sink (input valid, result_real, result_imag, status, output ready);
endinterface

// ----- sv/complex_arith_unit.sv -----
`timescale 1ns / 1ps
// Pipelined complex-number ALU in signed fixed point: add, sub, mul, div, conjugate, modulus.
//
//  Channel  Direction  Word contents
//  req      in         req_type, first_real, first_imag, second_real, second_imag
//  rsp      out        result_real, result_imag, status
//
// One word is accepted per cycle while the output buffer has room. The divide and square-root
// stages resolve one quotient bit of each part and one root bit per pipeline stage,
// after four stages of multiply, sum and setup.
// Reset clears all stage valid bits and the two-entry output buffer.
// The whole pipeline holds while the output buffer holds two words; nothing is lost.
`include "complex_arith_unit_defines.svh"

module complex_arith_unit #(
	parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH,
	parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	cau_req_if.sink req,
	cau_rsp_if.source rsp
);
	import cau_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int PW = 2 * DW;
	localparam int SW = 2 * DW + 1;
	localparam int MW = 2 * DW;
	localparam int NW = 2 * DW + FB;
	localparam int CW = NW + DW;
	localparam int XW = 2 * DW;
	localparam int NIT = DW;
	localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic dz;
		logic dovf_re;
		logic dovf_im;
		logic neg_re;
		logic neg_im;
		logic ovf;
		logic [DW-1:0] res_re;
		logic [DW-1:0] res_im;
		logic [PW-1:0] den;
		logic [NW-1:0] rre;
		logic [NW-1:0] rim;
		logic [DW-1:0] qre;
		logic [DW-1:0] qim;
		logic [XW-1:0] xr;
		logic [DW-1:0] rt;
	} it_t;

	typedef struct packed {
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic [ST_W-1:0] st;
	} res_t;

	// Saturate a sign and magnitude into the field; the top bit flags overflow.
	function automatic logic [DW:0] sat_fn(input logic neg, input logic [MW-1:0] mag);
		logic [MW-1:0] lim;
		logic [DW:0] r;
		lim = MW'(1) << (DW - 1);
		if (!neg || mag == '0) begin
			r = (mag >= lim) ? {1'b1, MAXV} : {1'b0, mag[DW-1:0]};
		end else begin
			r = (mag > lim) ? {1'b1, MINV} : {1'b0, ~mag[DW-1:0] + 1'b1};
		end
		return r;
	endfunction

	logic en;
	logic push;
	logic pop;
	logic [1:0] ob_cnt_q;
	logic ob_wp_q;
	logic ob_rp_q;
	res_t ob_q [2];
	res_t ob_head;
	res_t fin;

	// The pipeline moves whenever the output buffer has room.
	assign en = (ob_cnt_q != 2'd2);
	assign req.ready = en;

	// Stage 1: products, squares and the linear operations.
	logic v_s1;
	logic [OP_W-1:0] op_s1;
	logic signed [PW-1:0] prr_s1, pii_s1, pri_s1, pir_s1, sq0_s1, sq1_s1;
	logic signed [DW:0] lin_re_s1, lin_im_s1;
	logic signed [DW-1:0] sqa, sqb;
	logic signed [DW:0] ar_x, ai_x, br_x, bi_x, lre_c, lim_c;

	always_comb begin
		sqa = (req.req_type == OP_MOD) ? req.first_real : req.second_real;
		sqb = (req.req_type == OP_MOD) ? req.first_imag : req.second_imag;
		ar_x = (DW+1)'(req.first_real);
		ai_x = (DW+1)'(req.first_imag);
		br_x = (DW+1)'(req.second_real);
		bi_x = (DW+1)'(req.second_imag);
		unique case (req.req_type)
			OP_ADD: begin
				lre_c = ar_x + br_x;
				lim_c = ai_x + bi_x;
			end
			OP_SUB: begin
				lre_c = ar_x - br_x;
				lim_c = ai_x - bi_x;
			end
			OP_CONJ: begin
				lre_c = ar_x;
				lim_c = -ai_x;
			end
			default: begin
				lre_c = '0;
				lim_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= req.req_type;
			prr_s1 <= req.first_real * req.second_real;
			pii_s1 <= req.first_imag * req.second_imag;
			pri_s1 <= req.first_real * req.second_imag;
			pir_s1 <= req.first_imag * req.second_real;
			sq0_s1 <= sqa * sqa;
			sq1_s1 <= sqb * sqb;
			lin_re_s1 <= lre_c;
			lin_im_s1 <= lim_c;
		end
	end

	// Stage 2: sums of products and saturation of the linear results.
	logic v_s2;
	logic [OP_W-1:0] op_s2;
	logic signed [SW-1:0] cre_s2, cim_s2, cre_c, cim_c;
	logic [PW-1:0] sq_s2;
	logic [DW:0] lsat_re_s2, lsat_im_s2;
	logic [DW:0] lmag_re, lmag_im;

	always_comb begin
		if (op_s1 == OP_MUL) begin
			cre_c = SW'(prr_s1) - SW'(pii_s1);
			cim_c = SW'(pri_s1) + SW'(pir_s1);
		end else begin
			cre_c = SW'(prr_s1) + SW'(pii_s1);
			cim_c = SW'(pir_s1) - SW'(pri_s1);
		end
		lmag_re = lin_re_s1[DW] ? (~$unsigned(lin_re_s1) + 1'b1) : $unsigned(lin_re_s1);
		lmag_im = lin_im_s1[DW] ? (~$unsigned(lin_im_s1) + 1'b1) : $unsigned(lin_im_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			cre_s2 <= cre_c;
			cim_s2 <= cim_c;
			sq_s2 <= PW'($unsigned(sq0_s1)) + PW'($unsigned(sq1_s1));
			lsat_re_s2 <= sat_fn(lin_re_s1[DW], MW'(lmag_re));
			lsat_im_s2 <= sat_fn(lin_im_s1[DW], MW'(lmag_im));
		end
	end

	// Stage 3: sign and magnitude of the product sums.
	logic v_s3;
	logic [OP_W-1:0] op_s3;
	logic neg_re_s3, neg_im_s3;
	logic [MW-1:0] mag_re_s3, mag_im_s3;
	logic [PW-1:0] sq_s3;
	logic [DW:0] lsat_re_s3, lsat_im_s3;
	logic [SW-1:0] cm_re, cm_im;

	always_comb begin
		cm_re = cre_s2[SW-1] ? (~$unsigned(cre_s2) + 1'b1) : $unsigned(cre_s2);
		cm_im = cim_s2[SW-1] ? (~$unsigned(cim_s2) + 1'b1) : $unsigned(cim_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3 <= op_s2;
			neg_re_s3 <= cre_s2[SW-1];
			neg_im_s3 <= cim_s2[SW-1];
			mag_re_s3 <= cm_re[MW-1:0];
			mag_im_s3 <= cm_im[MW-1:0];
			sq_s3 <= sq_s2;
			lsat_re_s3 <= lsat_re_s2;
			lsat_im_s3 <= lsat_im_s2;
		end
	end

	// Stage 4: multiply results, divider and root setup.
	logic v_s4;
	it_t it_s4, it_n;
	logic [DW:0] msat_re, msat_im;
	logic [NW-1:0] nre, nim;

	always_comb begin
		msat_re = sat_fn(neg_re_s3, mag_re_s3 >> FB);
		msat_im = sat_fn(neg_im_s3, mag_im_s3 >> FB);
		nre = NW'(mag_re_s3) << FB;
		nim = NW'(mag_im_s3) << FB;
		it_n.op = op_s3;
		it_n.dz = (sq_s3 == '0);
		it_n.dovf_re = (nre >> DW) >= NW'(sq_s3);
		it_n.dovf_im = (nim >> DW) >= NW'(sq_s3);
		it_n.neg_re = neg_re_s3;
		it_n.neg_im = neg_im_s3;
		it_n.den = sq_s3;
		it_n.rre = nre;
		it_n.rim = nim;
		it_n.qre = '0;
		it_n.qim = '0;
		it_n.xr = sq_s3;
		it_n.rt = '0;
		unique case (op_s3)
			OP_ADD, OP_SUB, OP_CONJ: begin
				it_n.res_re = lsat_re_s3[DW-1:0];
				it_n.res_im = lsat_im_s3[DW-1:0];
				it_n.ovf = lsat_re_s3[DW] | lsat_im_s3[DW];
			end
			OP_MUL: begin
				it_n.res_re = msat_re[DW-1:0];
				it_n.res_im = msat_im[DW-1:0];
				it_n.ovf = msat_re[DW] | msat_im[DW];
			end
			default: begin
				it_n.res_re = '0;
				it_n.res_im = '0;
				it_n.ovf = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4 <= it_n;
		end
	end

	// Iteration stages: one quotient bit per part and one root bit each.
	logic [NIT-1:0] it_v_s5;
	it_t it_s5 [NIT];

	for (genvar k = 0; k < NIT; k++) begin : g_it
		localparam int BI = NIT - 1 - k;
		it_t pv;
		it_t nx;
		logic [CW-1:0] dsh;
		logic [XW+1:0] trial;
		logic ge_re, ge_im, ge_x;

		if (k == 0) begin : g_head
			assign pv = it_s4;
		end else begin : g_body
			assign pv = it_s5[k-1];
		end

		always_comb begin
			nx = pv;
			dsh = CW'(pv.den) << BI;
			ge_re = CW'(pv.rre) >= dsh;
			ge_im = CW'(pv.rim) >= dsh;
			if (ge_re) begin
				nx.rre = NW'(CW'(pv.rre) - dsh);
				nx.qre = pv.qre | (DW'(1) << BI);
			end
			if (ge_im) begin
				nx.rim = NW'(CW'(pv.rim) - dsh);
				nx.qim = pv.qim | (DW'(1) << BI);
			end
			trial = ((XW+2)'(pv.rt) << (BI + 1)) + ((XW+2)'(1) << (2 * BI));
			ge_x = (XW+2)'(pv.xr) >= trial;
			if (ge_x) begin
				nx.xr = XW'((XW+2)'(pv.xr) - trial);
				nx.rt = pv.rt | (DW'(1) << BI);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s5[k] <= nx;
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			it_v_s5 <= '0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			it_v_s5 <= {it_v_s5[NIT-2:0], v_s4};
		end
	end

	// Final result selection and saturation of quotient and root.
	it_t tail;
	logic [DW:0] qs_re, qs_im, rs;
	logic [DW-1:0] dre, dim;
	logic dovf;

	assign tail = it_s5[NIT-1];

	always_comb begin
		qs_re = sat_fn(tail.neg_re, MW'(tail.qre));
		qs_im = sat_fn(tail.neg_im, MW'(tail.qim));
		rs = sat_fn(1'b0, MW'(tail.rt));
		dre = tail.dovf_re ? (tail.neg_re ? MINV : MAXV) : qs_re[DW-1:0];
		dim = tail.dovf_im ? (tail.neg_im ? MINV : MAXV) : qs_im[DW-1:0];
		dovf = tail.dovf_re | tail.dovf_im | qs_re[DW] | qs_im[DW];
		unique case (tail.op)
			OP_DIV: begin
				if (tail.dz) begin
					fin.re = '0;
					fin.im = '0;
					fin.st = ST_DIV_ZERO;
				end else begin
					fin.re = dre;
					fin.im = dim;
					fin.st = dovf ? ST_OVERFLOW : ST_OK;
				end
			end
			OP_MOD: begin
				fin.re = rs[DW-1:0];
				fin.im = '0;
				fin.st = rs[DW] ? ST_OVERFLOW : ST_OK;
			end
			default: begin
				fin.re = tail.res_re;
				fin.im = tail.res_im;
				fin.st = tail.ovf ? ST_OVERFLOW : ST_OK;
			end
		endcase
	end

	// Two-word output buffer.
	assign push = en && it_v_s5[NIT-1];
	assign pop = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= 2'd0;
			ob_wp_q <= 1'b0;
			ob_rp_q <= 1'b0;
		end else begin
			if (push) begin
				ob_wp_q <= ~ob_wp_q;
			end
			if (pop) begin
				ob_rp_q <= ~ob_rp_q;
			end
			unique case ({push, pop})
				2'b10: ob_cnt_q <= ob_cnt_q + 2'd1;
				2'b01: ob_cnt_q <= ob_cnt_q - 2'd1;
				default: ob_cnt_q <= ob_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ob_q[ob_wp_q] <= fin;
		end
	end

	assign ob_head = ob_q[ob_rp_q];
	assign rsp.valid = (ob_cnt_q != 2'd0);
	assign rsp.result_real = $signed(ob_head.re);
	assign rsp.result_imag = $signed(ob_head.im);
	assign rsp.status = ob_head.st;

	// Checks.
	`CAU_ASSERT(a_cnt_range, ob_cnt_q != 2'd3)
	`CAU_ASSERT(a_valid_cnt, rsp.valid == (ob_cnt_q != 2'd0))
	`CAU_ASSERT_IMP(a_dz_zero, push && fin.st == ST_DIV_ZERO, fin.re == '0 && fin.im == '0)
	`CAU_ASSERT_IMP(a_mod_imag, push && tail.op == OP_MOD, fin.im == '0)
	`CAU_ASSERT_NXT(a_stall_hold, !en, $stable(it_v_s5) && $stable(v_s1) && $stable(v_s4))
endmodule
